// ----- rtl/ils_pkg.sv -----
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    // Index and length widths of the ports, sized for CAPACITY
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_COPY   = 3'd4,
        CMD_SWAP   = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_SRC,
        RD_TAIL
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_A,
        WR_B,
        WR_DST,
        WR_END
    } wr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_RDATA,
        WD_HOLD
    } wd_sel_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC,
        CNT_LOAD_DST
    } cnt_op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        wd_sel_t wd_sel;
        logic    hold_load;
        logic    ptr_init;
        logic    src_inc;
        logic    dst_inc;
        cnt_op_t cnt_op;
        logic    publish;
        status_t pub_status;
        logic    pub_take;
    } ils_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic a_ok;
        logic b_ok;
        logic range_ok;
        logic src_live;
        logic out_free;
    } ils_stat_t;

endpackage

// ----- rtl/ils_datapath.sv -----
// Datapath of the indexed list store: entry memory, length, shift pointers and result register.
module ils_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ils_pkg::CMD_W-1:0] command,
    input  logic [ils_pkg::DATA_W-1:0] value,
    input  logic [ils_pkg::IDX_W-1:0] index_a,
    input  logic [ils_pkg::IDX_W-1:0] index_b,
    input  ils_pkg::ils_ctl_t         ctl,
    output ils_pkg::ils_stat_t        stat,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [ils_pkg::STAT_W-1:0] status,
    output logic [ils_pkg::DATA_W-1:0] data_out,
    output logic [ils_pkg::CNT_W-1:0] length
);

    logic [ils_pkg::DATA_W-1:0] mem [ils_pkg::CAPACITY];

    ils_pkg::cmd_t              cmd_reg;
    logic [ils_pkg::DATA_W-1:0] value_reg;
    logic [ils_pkg::IDX_W-1:0]  ia_reg;
    logic [ils_pkg::IDX_W-1:0]  ib_reg;
    logic [ils_pkg::DATA_W-1:0] rdata_reg;
    logic [ils_pkg::DATA_W-1:0] hold_reg;
    logic [ils_pkg::CNT_W-1:0]  src_reg;
    logic [ils_pkg::CNT_W-1:0]  dst_reg;
    logic [ils_pkg::CNT_W-1:0]  count_reg;
    logic [ils_pkg::CNT_W-1:0]  count_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    ils_pkg::status_t           res_status_reg;
    logic [ils_pkg::DATA_W-1:0] res_data_reg;
    logic [ils_pkg::CNT_W-1:0]  res_len_reg;

    logic [ils_pkg::CNT_W-1:0]  ia_ext;
    logic [ils_pkg::CNT_W-1:0]  ib_ext;
    logic [ils_pkg::CNT_W-1:0]  tail;
    logic [ils_pkg::IDX_W-1:0]  hi_idx;
    logic [ils_pkg::IDX_W-1:0]  rd_addr;
    logic [ils_pkg::IDX_W-1:0]  wr_addr;
    logic [ils_pkg::DATA_W-1:0] wr_data;
    logic                       out_free;

    assign ia_ext   = {{(ils_pkg::CNT_W-ils_pkg::IDX_W){1'b0}}, ia_reg};
    assign ib_ext   = {{(ils_pkg::CNT_W-ils_pkg::IDX_W){1'b0}}, ib_reg};
    assign tail     = count_reg - ils_pkg::CNT_W'(1);
    assign hi_idx   = (cmd_reg == ils_pkg::CMD_ERASE) ? ib_reg : ia_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.full     = (count_reg == ils_pkg::CNT_W'(ils_pkg::CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.a_ok     = (ia_ext < count_reg);
        stat.b_ok     = (ib_ext < count_reg);
        stat.range_ok = (ia_reg <= ib_reg) && (ib_ext < count_reg);
        stat.src_live = (src_reg < count_reg);
        stat.out_free = out_free;
    end

    always_comb
    begin
        case (ctl.rd_sel)
            ils_pkg::RD_A:    rd_addr = ia_reg;
            ils_pkg::RD_B:    rd_addr = ib_reg;
            ils_pkg::RD_SRC:  rd_addr = src_reg[ils_pkg::IDX_W-1:0];
            ils_pkg::RD_TAIL: rd_addr = tail[ils_pkg::IDX_W-1:0];
            default:          rd_addr = ia_reg;
        endcase
        case (ctl.wr_sel)
            ils_pkg::WR_A:   wr_addr = ia_reg;
            ils_pkg::WR_B:   wr_addr = ib_reg;
            ils_pkg::WR_DST: wr_addr = dst_reg[ils_pkg::IDX_W-1:0];
            ils_pkg::WR_END: wr_addr = count_reg[ils_pkg::IDX_W-1:0];
            default:         wr_addr = ia_reg;
        endcase
        case (ctl.wd_sel)
            ils_pkg::WD_VALUE: wr_data = value_reg;
            ils_pkg::WD_RDATA: wr_data = rdata_reg;
            ils_pkg::WD_HOLD:  wr_data = hold_reg;
            default:           wr_data = value_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.cnt_op)
            ils_pkg::CNT_KEEP:     count_next = count_reg;
            ils_pkg::CNT_INC:      count_next = count_reg + ils_pkg::CNT_W'(1);
            ils_pkg::CNT_DEC:      count_next = tail;
            ils_pkg::CNT_LOAD_DST: count_next = dst_reg;
            default:               count_next = count_reg;
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (ctl.publish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Single write port and single registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= ils_pkg::cmd_t'(command);
            value_reg <= value;
            ia_reg    <= index_a;
            ib_reg    <= index_b;
        end
        if (ctl.hold_load)
        begin
            hold_reg <= rdata_reg;
        end
        // Shift starts just past the dropped span and lands on its first slot
        if (ctl.ptr_init)
        begin
            src_reg <= {{(ils_pkg::CNT_W-ils_pkg::IDX_W){1'b0}}, hi_idx}
                       + ils_pkg::CNT_W'(1);
            dst_reg <= ia_ext;
        end
        else
        begin
            if (ctl.src_inc)
            begin
                src_reg <= src_reg + ils_pkg::CNT_W'(1);
            end
            if (ctl.dst_inc)
            begin
                dst_reg <= dst_reg + ils_pkg::CNT_W'(1);
            end
        end
        if (ctl.publish)
        begin
            res_status_reg <= ctl.pub_status;
            res_data_reg   <= ctl.pub_take ? hold_reg : '0;
            res_len_reg    <= count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = res_status_reg;
    assign data_out  = res_data_reg;
    assign length    = res_len_reg;

endmodule

// ----- rtl/ils_ctrl.sv -----
// Controller of the indexed list store: sequences memory accesses for each command.
module ils_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               busy,
    input  ils_pkg::ils_stat_t stat,
    output ils_pkg::ils_ctl_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WB,
        S_REM_RD,
        S_SHIFT,
        S_COPY_WR,
        S_SWAP_RB,
        S_SWAP_WA,
        S_SWAP_WB,
        S_RESULT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    ils_pkg::status_t  res_status_reg;
    ils_pkg::status_t  res_status_next;
    logic              take_reg;
    logic              take_next;
    logic              pend_reg;
    logic              pend_next;

    always_comb
    begin
        ctl             = '0;
        ctl.pub_status  = res_status_reg;
        ctl.pub_take    = take_reg;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        take_next       = take_reg;
        pend_next       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    take_next   = 1'b0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_status_next = ils_pkg::ST_OK;
                state_next      = S_RESULT;
                case (stat.cmd)
                    ils_pkg::CMD_PUSH:
                    begin
                        if (stat.full)
                        begin
                            res_status_next = ils_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.wr_en  = 1'b1;
                            ctl.wr_sel = ils_pkg::WR_END;
                            ctl.wd_sel = ils_pkg::WD_VALUE;
                            ctl.cnt_op = ils_pkg::CNT_INC;
                        end
                    end
                    ils_pkg::CMD_POP:
                    begin
                        if (stat.empty)
                        begin
                            res_status_next = ils_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = ils_pkg::RD_TAIL;
                            state_next = S_POP_WB;
                        end
                    end
                    ils_pkg::CMD_ERASE:
                    begin
                        if (!stat.range_ok)
                        begin
                            res_status_next = ils_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            ctl.ptr_init = 1'b1;
                            state_next   = S_SHIFT;
                        end
                    end
                    ils_pkg::CMD_REMOVE:
                    begin
                        if (!stat.a_ok)
                        begin
                            res_status_next = ils_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            ctl.rd_en    = 1'b1;
                            ctl.rd_sel   = ils_pkg::RD_A;
                            ctl.ptr_init = 1'b1;
                            state_next   = S_REM_RD;
                        end
                    end
                    ils_pkg::CMD_COPY:
                    begin
                        if (!stat.a_ok || !stat.b_ok)
                        begin
                            res_status_next = ils_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = ils_pkg::RD_B;
                            state_next = S_COPY_WR;
                        end
                    end
                    ils_pkg::CMD_SWAP:
                    begin
                        if (!stat.a_ok || !stat.b_ok)
                        begin
                            res_status_next = ils_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = ils_pkg::RD_A;
                            state_next = S_SWAP_RB;
                        end
                    end
                    default:
                    begin
                        res_status_next = ils_pkg::ST_BAD_INDEX;
                    end
                endcase
            end

            S_POP_WB:
            begin
                ctl.hold_load = 1'b1;
                ctl.cnt_op    = ils_pkg::CNT_DEC;
                take_next     = 1'b1;
                state_next    = S_RESULT;
            end

            S_REM_RD:
            begin
                ctl.hold_load = 1'b1;
                take_next     = 1'b1;
                state_next    = S_SHIFT;
            end

            S_SHIFT:
            begin
                // Read one word ahead, write the word read last cycle
                ctl.rd_en   = stat.src_live;
                ctl.rd_sel  = ils_pkg::RD_SRC;
                ctl.src_inc = stat.src_live;
                pend_next   = stat.src_live;
                if (pend_reg)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_sel  = ils_pkg::WR_DST;
                    ctl.wd_sel  = ils_pkg::WD_RDATA;
                    ctl.dst_inc = 1'b1;
                end
                if (!stat.src_live && !pend_reg)
                begin
                    ctl.cnt_op = ils_pkg::CNT_LOAD_DST;
                    state_next = S_RESULT;
                end
            end

            S_COPY_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = ils_pkg::WR_A;
                ctl.wd_sel = ils_pkg::WD_RDATA;
                state_next = S_RESULT;
            end

            S_SWAP_RB:
            begin
                ctl.hold_load = 1'b1;
                ctl.rd_en     = 1'b1;
                ctl.rd_sel    = ils_pkg::RD_B;
                state_next    = S_SWAP_WA;
            end

            S_SWAP_WA:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = ils_pkg::WR_A;
                ctl.wd_sel = ils_pkg::WD_RDATA;
                state_next = S_SWAP_WB;
            end

            S_SWAP_WB:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = ils_pkg::WR_B;
                ctl.wd_sel = ils_pkg::WD_HOLD;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                // Hold until the result register can take the beat
                if (stat.out_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ils_pkg::ST_OK;
            take_reg       <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            take_reg       <= take_next;
            pend_reg       <= pend_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/indexed_list_store.sv -----
// Top level of the indexed list store: controller, datapath and result checks.
//
//  channel   direction  handshake             fields
//  command   in         cmd_valid/cmd_stall   command, value, index_a, index_b
//  result    out        rsp_valid/rsp_stall   status, data_out, length
//
// One command is worked at a time; its result is registered in the result state once the
// result register is free. Push and rejected commands go from decode to the result; pop adds
// a read-back state, copy a write state, swap a second read and two writes. Erase and remove
// move the tail down one word per cycle through the separate read and write memory ports.
// The next command is taken the cycle after a result is registered, even while it stalls.
// Reset clears the length; entry contents are left as they are and need no clearing pass.
module indexed_list_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [ils_pkg::CMD_W-1:0]  command,
    input  logic [ils_pkg::DATA_W-1:0] value,
    input  logic [ils_pkg::IDX_W-1:0]  index_a,
    input  logic [ils_pkg::IDX_W-1:0]  index_b,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [ils_pkg::STAT_W-1:0] status,
    output logic [ils_pkg::DATA_W-1:0] data_out,
    output logic [ils_pkg::CNT_W-1:0]  length
);

    ils_pkg::ils_ctl_t  ctl;
    ils_pkg::ils_stat_t stat;
    logic               busy;

    ils_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .busy      (busy),
        .stat      (stat),
        .ctl       (ctl)
    );

    ils_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .value     (value),
        .index_a   (index_a),
        .index_b   (index_b),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .data_out  (data_out),
        .length    (length)
    );

    assign cmd_stall = busy;

    // One command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while another is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> length <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
    else $error("length above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ils_pkg::ST_FULL
        |-> length == ils_pkg::CNT_W'(ils_pkg::CAPACITY))
    else $error("full reported below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ils_pkg::ST_EMPTY |-> length == '0 && data_out == '0)
    else $error("empty reported with entries held");

    // A result is registered only when the controller sequence closes
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.publish |-> !(rsp_valid && rsp_stall))
    else $error("result overwritten while stalled");

endmodule

// ----- dv/tb_indexed_list_store.sv -----
// Self-checking testbench for the indexed list store: directed and random command streams.
`timescale 1ns / 100ps

module tb_indexed_list_store;

    import ils_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam int SETTLE      = 100;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 48;

    // Command codes the block does not implement
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {GROW_MIX, CHURN_MIX, SHRINK_MIX} mix_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data;
        logic [CNT_W-1:0]    length;
    } list_result_t;

    class list_scoreboard;
        logic [DATA_W-1:0] words [CAPACITY];
        int                count;
        int                errors;
        list_result_t      awaited [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Drop lo..hi inclusive and shift the tail down
        function void close_gap(int lo, int hi);
            int gap;
            int k;
            gap = hi - lo + 1;
            for (k = hi + 1; k < count; k++)
                words[k - gap] = words[k];
            count -= gap;
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [DATA_W-1:0] word,
                                   logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib);
            list_result_t      res;
            logic [DATA_W-1:0] held;
            bit                a_ok;
            bit                b_ok;
            res.status = ST_OK;
            res.data   = '0;
            a_ok = int'(ia) < count;
            b_ok = int'(ib) < count;
            case (op)
                CMD_PUSH:
                    if (count >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        words[count] = word;
                        count++;
                    end
                CMD_POP:
                    if (count == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        count--;
                        res.data = words[count];
                    end
                CMD_ERASE:
                    if (ia > ib || !b_ok)
                        res.status = ST_BAD_INDEX;
                    else
                        close_gap(ia, ib);
                CMD_REMOVE:
                    if (!a_ok)
                        res.status = ST_BAD_INDEX;
                    else
                    begin
                        res.data = words[ia];
                        close_gap(ia, ia);
                    end
                CMD_COPY:
                    if (!a_ok || !b_ok)
                        res.status = ST_BAD_INDEX;
                    else
                        words[ia] = words[ib];
                CMD_SWAP:
                    if (!a_ok || !b_ok)
                        res.status = ST_BAD_INDEX;
                    else
                    begin
                        held      = words[ia];
                        words[ia] = words[ib];
                        words[ib] = held;
                    end
                default:
                    res.status = ST_BAD_INDEX;
            endcase
            res.length = CNT_W'(count);
            awaited.push_back(res);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] data,
                                   logic [CNT_W-1:0] len);
            list_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result status %0d data %h length %0d",
                         $time, st, data, len);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (want.status != st)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, st);
                errors++;
            end
            if (want.data != data)
            begin
                $display("%0t: data_out expected %h got %h", $time, want.data, data);
                errors++;
            end
            if (want.length != len)
            begin
                $display("%0t: length expected %0d got %0d", $time, want.length, len);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  length;

    list_scoreboard sb = new();

    bit send_idle_on  = 1'b0;
    bit rsp_idle_on   = 1'b0;
    bit long_hold_req = 1'b0;
    int cycle_count   = 0;

    indexed_list_store DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .value     (value),
        .index_a   (index_a),
        .index_b   (index_b),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .data_out  (data_out),
        .length    (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(status, data_out, length);
    end

    // Result side: short random stalls, or one long hold-off on request
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else if (rsp_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat, valid left high
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] word,
                                input logic [IDX_W-1:0] ia, input logic [IDX_W-1:0] ib);
        cmd_valid <= 1'b1;
        command   <= op;
        value     <= word;
        index_a   <= ia;
        index_b   <= ib;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(op, word, ia, ib);
        @(negedge clk);
    endtask

    task automatic pace();
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    // Hold the sender until every outstanding result has been seen
    task automatic wait_until_drained();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [IDX_W-1:0] pick_index(input int len);
        if (len == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 63));
        return IDX_W'($urandom_range(0, len - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            GROW_MIX:
                return roll < 50 ? CMD_PUSH : roll < 58 ? CMD_POP : roll < 62 ? CMD_ERASE :
                       roll < 70 ? CMD_REMOVE : roll < 85 ? CMD_COPY : CMD_SWAP;
            CHURN_MIX:
                return roll < 25 ? CMD_PUSH : roll < 45 ? CMD_POP : roll < 50 ? CMD_ERASE :
                       roll < 65 ? CMD_REMOVE : roll < 82 ? CMD_COPY : CMD_SWAP;
            default:
                return roll < 15 ? CMD_PUSH : roll < 40 ? CMD_POP : roll < 55 ? CMD_ERASE :
                       roll < 80 ? CMD_REMOVE : roll < 90 ? CMD_COPY : CMD_SWAP;
        endcase
    endfunction

    task automatic send_random(input mix_t mix);
        int                len;
        int                roll;
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] word;
        logic [IDX_W-1:0]  ia;
        logic [IDX_W-1:0]  ib;
        logic [IDX_W-1:0]  t;
        len  = sb.count;
        word = $urandom;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            word = '0;
        else if (roll == 1)
            word = '1;
        ia = pick_index(len);
        ib = pick_index(len);
        if ($urandom_range(0, 99) < 4)
        begin
            // noise: any code, any indices
            op = CMD_W'($urandom_range(0, 7));
            ia = IDX_W'($urandom_range(0, 63));
            ib = IDX_W'($urandom_range(0, 63));
        end
        else
        begin
            op = pick_command(mix);
            if (op == CMD_ERASE && len > 0)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                begin
                    ia = '0;
                    ib = IDX_W'(len - 1);
                end
                else if (roll < 18 && ia > ib)
                begin
                    t  = ia;
                    ia = ib;
                    ib = t;
                end
            end
        end
        send_command(op, word, ia, ib);
    endtask

    initial
    begin
        int phase;
        int n;
        bit quiet;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        command   = CMD_PUSH;
        value     = '0;
        index_a   = '0;
        index_b   = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_on = 1'b1;
        rsp_idle_on  = 1'b1;

        // empty list: every command that reads is refused
        send_command(CMD_POP, 32'hFFFF_FFFF, 6'd0, 6'd0);
        send_command(CMD_REMOVE, '0, 6'd0, 6'd0);
        send_command(CMD_ERASE, '0, 6'd0, 6'd0);
        send_command(CMD_COPY, '0, 6'd0, 6'd0);
        send_command(CMD_SWAP, '0, 6'd0, 6'd0);
        send_command(CMD_SPARE_LO, '0, 6'd0, 6'd0);
        send_command(CMD_SPARE_HI, '1, 6'd63, 6'd63);
        send_command(CMD_PUSH, 32'h0000_0000, 6'd63, 6'd0);
        send_command(CMD_PUSH, 32'hFFFF_FFFF, 6'd0, 6'd63);
        send_command(CMD_PUSH, 32'hA5A5_A5A5, 6'd21, 6'd42);
        send_command(CMD_PUSH, 32'h5A5A_5A5A, 6'd42, 6'd21);
        send_command(CMD_PUSH, 32'h1234_5678, 6'd0, 6'd0);
        // self copy and self swap change nothing
        send_command(CMD_COPY, '0, 6'd2, 6'd2);
        send_command(CMD_SWAP, '0, 6'd1, 6'd1);
        send_command(CMD_COPY, '0, 6'd0, 6'd4);
        send_command(CMD_SWAP, '0, 6'd1, 6'd3);
        // start above end, end at length, indices past the tail
        send_command(CMD_ERASE, '0, 6'd3, 6'd1);
        send_command(CMD_ERASE, '0, 6'd1, 6'd5);
        send_command(CMD_REMOVE, '0, 6'd63, 6'd0);
        send_command(CMD_COPY, '0, 6'd63, 6'd0);
        send_command(CMD_SWAP, '0, 6'd0, 6'd63);
        send_command(CMD_REMOVE, '0, 6'd1, 6'd0);
        send_command(CMD_ERASE, '0, 6'd0, 6'd1);
        send_command(CMD_POP, '0, 6'd0, 6'd0);
        send_command(CMD_POP, '0, 6'd0, 6'd0);
        wait_until_drained();

        // fill to capacity, then push against a full list
        while (sb.count < CAPACITY)
        begin
            send_command(CMD_PUSH, $urandom, IDX_W'($urandom_range(0, 63)),
                         IDX_W'($urandom_range(0, 63)));
            pace();
        end
        repeat (3)
        begin
            send_command(CMD_PUSH, $urandom, '0, '0);
            pace();
        end
        send_command(CMD_COPY, '0, 6'd63, 6'd0);
        send_command(CMD_SWAP, '0, 6'd0, 6'd63);

        for (phase = 0; phase < PHASES; phase++)
        begin
            quiet        = phase >= PHASES - 3;
            send_idle_on = !quiet && $urandom_range(0, 2) != 0;
            rsp_idle_on  = !quiet && $urandom_range(0, 2) != 0;
            if (phase == 4)
            begin
                // keep offering while the result side is held off
                send_idle_on  = 1'b0;
                long_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_random(mix_t'(phase % 3));
                pace();
            end
            if (phase % 4 == 3)
                wait_until_drained();
        end

        rsp_idle_on = 1'b0;
        wait_until_drained();
        repeat (SETTLE) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
